// ===== rtl/gbts_pkg.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text store package
// Item kinds, result status codes, controller states and the command and
// status structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gbts_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_MOVE   = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOTHING = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MV_RD,
    S_MV_WR,
    S_RD_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic mv_rd;
    logic mv_wr;
    logic rd_cap;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  mv_none;
    logic  rd_bad;
    logic  mv_last;
  } sts_t;

endpackage

// ===== rtl/gap_buffer_text_store.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text store
// Fixed-capacity editor text store that keeps a gap at the cursor.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and exactly one result
// follows, shown for a single cycle while done_o is high; the receiver cannot
// hold it off, so it must take it in that cycle. Insert, delete, a refused item
// and a move that goes nowhere pass from the transfer through the execute state
// to the strobe; a read adds a state capturing the store's read data, and a move
// of d positions adds a read and a write state per position, since every byte
// crossing the gap is read from and written back to the single text store. busy
// falls in the cycle after the strobe. The store needs no clearing after reset.
module gap_buffer_text_store #(
  parameter int unsigned CAPACITY = 1024,
  localparam int unsigned PW = $clog2(CAPACITY + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    kind_i,
  input  logic [7:0]    byte_in_i,
  input  logic [PW-1:0] position_i,
  output logic          done_o,
  output logic [7:0]    byte_out_o,
  output logic [PW-1:0] cursor_now_o,
  output logic [PW-1:0] text_length_o,
  output logic [1:0]    status_o
);

  import gbts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gbts_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  gbts_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (kind_i),
    .byte_in_i    (byte_in_i),
    .position_i   (position_i),
    .byte_out_o   (byte_out_o),
    .cursor_now_o (cursor_now_o),
    .text_length_o(text_length_o),
    .status_o     (status_o)
  );

endmodule

// ===== rtl/gbts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gbts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Gap buffer controller
// Sequences each item: decode, byte-by-byte copy across the gap for moves,
// store read for reads, and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module gbts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  input  gbts_pkg::sts_t sts_i,
  output gbts_pkg::cmd_t cmd_o
);

  import gbts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        case (sts_i.kind)
          KIND_MOVE: state_d = sts_i.mv_none ? S_DONE : S_MV_RD;
          KIND_READ: state_d = sts_i.rd_bad ? S_DONE : S_RD_WAIT;
          default:   state_d = S_DONE;
        endcase
      end
      S_MV_RD: begin
        cmd_o.mv_rd = 1'b1;
        state_d     = S_MV_WR;
      end
      S_MV_WR: begin
        cmd_o.mv_wr = 1'b1;
        state_d     = sts_i.mv_last ? S_DONE : S_MV_RD;
      end
      S_RD_WAIT: begin
        cmd_o.rd_cap = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// ===== rtl/gbts_dp.sv =====
// ----------------------------------------------------------------------------
// Gap buffer datapath
// Cursor and gap registers, address generation around the gap, the text
// store and the result registers.
// ----------------------------------------------------------------------------
module gbts_dp #(
  parameter int unsigned CAPACITY = 1024,
  localparam int unsigned PW = $clog2(CAPACITY + 1),
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gbts_pkg::cmd_t cmd_i,
  output gbts_pkg::sts_t sts_o,
  input  logic [1:0]     kind_i,
  input  logic [7:0]     byte_in_i,
  input  logic [PW-1:0]  position_i,
  output logic [7:0]     byte_out_o,
  output logic [PW-1:0]  cursor_now_o,
  output logic [PW-1:0]  text_length_o,
  output logic [1:0]     status_o
);

  import gbts_pkg::*;

  localparam logic [PW-1:0] CapVal = PW'(CAPACITY);
  localparam logic [PW-1:0] One    = PW'(1);

  logic [PW-1:0] cursor_q, cursor_d;
  logic [PW-1:0] gap_q, gap_d;
  kind_e         kind_q;
  logic [7:0]    byte_q;
  logic [PW-1:0] pos_q;
  status_e       status_q;
  logic [7:0]    byte_out_q;

  logic [PW-1:0] len;
  logic [PW-1:0] target;
  logic          mv_left;
  logic [PW:0]   cur_gap;
  logic [PW:0]   pos_gap;
  logic [PW:0]   curm1_gap;
  logic [PW-1:0] cur_m1;
  logic [PW-1:0] cur_p1;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign len       = CapVal - gap_q;
  assign target    = (pos_q > len) ? len : pos_q;
  assign mv_left   = (target < cursor_q);
  assign cur_m1    = cursor_q - One;
  assign cur_p1    = cursor_q + One;
  assign cur_gap   = {1'b0, cursor_q} + {1'b0, gap_q};
  assign pos_gap   = {1'b0, pos_q} + {1'b0, gap_q};
  assign curm1_gap = {1'b0, cur_m1} + {1'b0, gap_q};

  assign sts_o.kind    = kind_q;
  assign sts_o.mv_none = (target == cursor_q);
  assign sts_o.rd_bad  = (pos_q >= len);
  assign sts_o.mv_last = mv_left ? (cur_m1 == target) : (cur_p1 == target);

  always_comb begin
    cursor_d  = cursor_q;
    gap_d     = gap_q;
    ram_we    = 1'b0;
    ram_waddr = cursor_q[AW-1:0];
    ram_wdata = byte_q;
    ram_raddr = cur_m1[AW-1:0];
    if (cmd_i.exec) begin
      case (kind_q)
        KIND_INSERT: begin
          if (gap_q != '0) begin
            ram_we   = 1'b1;
            cursor_d = cur_p1;
            gap_d    = gap_q - One;
          end
        end
        KIND_DELETE: begin
          if (cursor_q != '0) begin
            cursor_d = cur_m1;
            gap_d    = gap_q + One;
          end
        end
        KIND_READ: begin
          ram_raddr = (pos_q < cursor_q) ? pos_q[AW-1:0] : pos_gap[AW-1:0];
        end
        default: begin
        end
      endcase
    end else if (cmd_i.mv_rd) begin
      ram_raddr = mv_left ? cur_m1[AW-1:0] : cur_gap[AW-1:0];
    end else if (cmd_i.mv_wr) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
      if (mv_left) begin
        ram_waddr = curm1_gap[AW-1:0];
        cursor_d  = cur_m1;
      end else begin
        ram_waddr = cursor_q[AW-1:0];
        cursor_d  = cur_p1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      gap_q    <= CapVal;
    end else begin
      cursor_q <= cursor_d;
      gap_q    <= gap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_e'(kind_i);
      byte_q <= byte_in_i;
      pos_q  <= position_i;
    end
    if (cmd_i.exec) begin
      byte_out_q <= '0;
      case (kind_q)
        KIND_INSERT: status_q <= (gap_q == '0) ? ST_FULL : ST_DONE;
        KIND_DELETE: status_q <= (cursor_q == '0) ? ST_NOTHING : ST_DONE;
        KIND_MOVE:   status_q <= (target == cursor_q) ? ST_NOTHING : ST_DONE;
        KIND_READ:   status_q <= (pos_q >= len) ? ST_RANGE : ST_DONE;
        default:     status_q <= ST_DONE;
      endcase
    end
    if (cmd_i.rd_cap) begin
      byte_out_q <= ram_rdata;
    end
  end

  gbts_ram #(
    .WIDTH(8),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign byte_out_o    = byte_out_q;
  assign cursor_now_o  = cursor_q;
  assign text_length_o = len;
  assign status_o      = status_q;

endmodule

// ===== rtl/gbts_chk.sv =====
// ----------------------------------------------------------------------------
// Gap buffer port checker
// Watches the top level ports for strobe, cursor and length consistency.
// ----------------------------------------------------------------------------
module gbts_chk #(
  parameter int unsigned CAPACITY = 1024,
  localparam int unsigned PW = $clog2(CAPACITY + 1)
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input logic [PW-1:0] cursor_now_o,
  input logic [PW-1:0] text_length_o,
  input logic [1:0]    status_o
);

  import gbts_pkg::*;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe held for more than one cycle.");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("Transfer not followed by a busy cycle.");

  a_cursor_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((cursor_now_o <= text_length_o) && (text_length_o <= PW'(CAPACITY))))
    else $error("Cursor or length out of range.");

  a_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (text_length_o == PW'(CAPACITY)))
    else $error("Full status reported with room left.");

endmodule

bind gap_buffer_text_store gbts_chk #(
  .CAPACITY(CAPACITY)
) u_gbts_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .cursor_now_o (cursor_now_o),
  .text_length_o(text_length_o),
  .status_o     (status_o)
);

// ===== test/tb_gap_buffer_text_store.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text store testbench
// Drives insert, delete, move and read commands into the text store and checks
// every result strobe against a behavioural copy of the buffer kept in a small
// scoreboard. A directed opening covers the corner cases of an empty text, then
// mixed random editing runs in bursts, the text is filled to capacity and the
// full buffer is exercised before a second stretch of random editing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gap_buffer_text_store;
  import gbts_pkg::*;

  localparam int unsigned CAP = 1024;
  localparam int unsigned PW = 11;

  typedef struct {
    logic [7:0]    byte_out;
    logic [PW-1:0] cursor_now;
    logic [PW-1:0] text_length;
    status_e       status;
  } edit_result_t;

  class edit_scoreboard;
    logic [7:0]   text [CAP];
    int unsigned  cursor;
    int unsigned  gap;
    edit_result_t awaited[$];
    int unsigned  errors;
    int unsigned  kinds_seen [4];
    int unsigned  status_seen [4];
    int unsigned  peak_length;

    function new();
      foreach (text[i]) text[i] = 8'h00;
      cursor = 0;
      gap = CAP;
      errors = 0;
      peak_length = 0;
    endfunction

    function int unsigned text_len();
      return CAP - gap;
    endfunction

    function void note_edit(kind_e kind, logic [7:0] data, logic [PW-1:0] pos);
      edit_result_t r;
      int unsigned  target;
      int unsigned  span;
      int unsigned  dst;
      int unsigned  src;
      r.byte_out = 8'h00;
      r.status = ST_DONE;
      case (kind)
        KIND_INSERT: begin
          if (gap == 0) begin
            r.status = ST_FULL;
          end else begin
            text[cursor] = data;
            cursor++;
            gap--;
          end
        end
        KIND_DELETE: begin
          if (cursor == 0) begin
            r.status = ST_NOTHING;
          end else begin
            cursor--;
            gap++;
          end
        end
        KIND_MOVE: begin
          target = (pos > text_len()) ? text_len() : pos;
          if (target == cursor) begin
            r.status = ST_NOTHING;
          end else if (target < cursor) begin
            // Bytes left of the old cursor go to the top of the gap, highest first.
            span = cursor - target;
            dst = cursor + gap - span;
            src = target;
            for (int i = int'(span) - 1; i >= 0; i--) text[dst + i] = text[src + i];
            cursor = target;
          end else begin
            span = target - cursor;
            dst = cursor;
            src = cursor + gap;
            for (int i = 0; i < int'(span); i++) text[dst + i] = text[src + i];
            cursor = target;
          end
        end
        default: begin
          if (pos >= text_len()) begin
            r.status = ST_RANGE;
          end else begin
            r.byte_out = (pos < cursor) ? text[pos] : text[pos + gap];
          end
        end
      endcase
      r.cursor_now = cursor[PW-1:0];
      r.text_length = PW'(text_len());
      awaited.push_back(r);
      kinds_seen[kind]++;
      status_seen[r.status]++;
      if (text_len() > peak_length) peak_length = text_len();
    endfunction

    function void check_result(logic [7:0] data, logic [PW-1:0] cur,
                               logic [PW-1:0] len, logic [1:0] st);
      edit_result_t r;
      if (awaited.size() == 0) begin
        $error("result strobe with no command outstanding");
        errors++;
        return;
      end
      r = awaited.pop_front();
      if (data !== r.byte_out) begin
        $error("byte_out mismatch: expected %0d, actual %0d", r.byte_out, data);
        errors++;
      end
      if (cur !== r.cursor_now) begin
        $error("cursor_now mismatch: expected %0d, actual %0d", r.cursor_now, cur);
        errors++;
      end
      if (len !== r.text_length) begin
        $error("text_length mismatch: expected %0d, actual %0d", r.text_length, len);
        errors++;
      end
      if (st !== r.status) begin
        $error("status mismatch: expected %0d, actual %0d", r.status, st);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [1:0]    kind_i = KIND_INSERT;
  logic [7:0]    byte_in_i = 8'h00;
  logic [PW-1:0] position_i = '0;
  logic          done_o;
  logic [7:0]    byte_out_o;
  logic [PW-1:0] cursor_now_o;
  logic [PW-1:0] text_length_o;
  logic [1:0]    status_o;

  edit_scoreboard edits = new();
  int unsigned    burst_left = 0;
  bit             steady = 1'b0;

  gap_buffer_text_store #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .byte_in_i    (byte_in_i),
    .position_i   (position_i),
    .done_o       (done_o),
    .byte_out_o   (byte_out_o),
    .cursor_now_o (cursor_now_o),
    .text_length_o(text_length_o),
    .status_o     (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      edits.check_result(byte_out_o, cursor_now_o, text_length_o, status_o);
    end
  end

  task automatic send_edit(kind_e kind, logic [7:0] data, logic [PW-1:0] pos);
    start <= 1'b1;
    kind_i <= kind;
    byte_in_i <= data;
    position_i <= pos;
    do @(posedge clk_i); while (busy);
    edits.note_edit(kind, data, pos);
  endtask

  task automatic idle_for(int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic pace();
    if (!steady) begin
      if (burst_left == 0) begin
        idle_for($urandom_range(1, 15));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    while (edits.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_edit(int unsigned insert_weight);
    kind_e       kind;
    int          pos;
    int unsigned len;
    int unsigned pick;
    int unsigned roll;
    len = edits.text_len();
    pick = $urandom_range(0, 99);
    roll = $urandom_range(0, 9);
    pos = int'($urandom_range(0, 2047));
    if (pick < insert_weight) kind = KIND_INSERT;
    else if (pick < insert_weight + 15) kind = KIND_DELETE;
    else if (pick < insert_weight + 35) kind = KIND_MOVE;
    else kind = KIND_READ;
    if (kind == KIND_MOVE) begin
      if (roll < 7) begin
        pos = int'(edits.cursor) + int'($urandom_range(0, 32)) - 16;
        if (pos < 0) pos = 0;
        if (pos > int'(len)) pos = int'(len);
      end else if (roll < 9) begin
        pos = int'($urandom_range(0, len));
      end
    end else if (kind == KIND_READ && roll < 8 && len > 0) begin
      pos = int'($urandom_range(0, len - 1));
    end
    send_edit(kind, 8'($urandom_range(0, 255)), pos[PW-1:0]);
    pace();
  endtask

  task automatic random_stretch(int unsigned count, int unsigned insert_weight);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 25 == 0) steady = ($urandom_range(0, 2) == 0);
      random_edit(insert_weight);
    end
  endtask

  task automatic fill_and_probe();
    wait_quiet();
    send_edit(KIND_MOVE, 8'h00, PW'(edits.text_len() / 2));
    while (edits.gap != 0) begin
      send_edit(KIND_INSERT, 8'($urandom_range(0, 255)), PW'($urandom_range(0, 2047)));
      pace();
    end
    send_edit(KIND_INSERT, 8'h00, 11'd0);
    send_edit(KIND_INSERT, 8'hFF, 11'h7FF);
    send_edit(KIND_READ, 8'h00, 11'd0);
    send_edit(KIND_READ, 8'h00, 11'd1023);
    send_edit(KIND_READ, 8'h00, 11'd1024);
    send_edit(KIND_MOVE, 8'h00, 11'd0);
    send_edit(KIND_READ, 8'h00, 11'd512);
    send_edit(KIND_MOVE, 8'h00, 11'd1024);
    send_edit(KIND_MOVE, 8'h00, 11'h7FF);
    send_edit(KIND_MOVE, 8'h00, PW'($urandom_range(1, 1023)));
    send_edit(KIND_INSERT, 8'h5A, 11'd0);
    send_edit(KIND_DELETE, 8'h00, 11'd0);
    send_edit(KIND_INSERT, 8'hC3, 11'd0);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_edit(KIND_READ, 8'h00, 11'd0);
    send_edit(KIND_DELETE, 8'h00, 11'd0);
    send_edit(KIND_MOVE, 8'h00, 11'd0);
    send_edit(KIND_MOVE, 8'h00, 11'h7FF);
    send_edit(KIND_INSERT, 8'h00, 11'd0);
    send_edit(KIND_INSERT, 8'hFF, 11'h7FF);
    send_edit(KIND_INSERT, 8'hA5, 11'd0);
    send_edit(KIND_INSERT, 8'h5A, 11'd0);
    send_edit(KIND_READ, 8'h00, 11'd0);
    send_edit(KIND_READ, 8'h00, 11'd3);
    send_edit(KIND_READ, 8'h00, 11'd4);
    send_edit(KIND_READ, 8'h00, 11'h7FF);
    send_edit(KIND_MOVE, 8'h00, 11'd1);
    send_edit(KIND_READ, 8'h00, 11'd2);
    send_edit(KIND_INSERT, 8'h3C, 11'd0);
    send_edit(KIND_READ, 8'h00, 11'd1);
    send_edit(KIND_MOVE, 8'h00, 11'd1024);
    send_edit(KIND_DELETE, 8'h00, 11'd0);
    send_edit(KIND_MOVE, 8'h00, 11'd0);
    send_edit(KIND_DELETE, 8'h00, 11'd0);
    send_edit(KIND_READ, 8'h00, 11'd3);
    send_edit(KIND_MOVE, 8'h00, 11'd2);

    random_stretch(50, 40);
    fill_and_probe();
    random_stretch(50, 20);

    wait_quiet();
    repeat (16) @(posedge clk_i);
    $display("Covered %0d inserts, %0d deletes, %0d moves and %0d reads; peak text %0d of %0d.",
             edits.kinds_seen[KIND_INSERT], edits.kinds_seen[KIND_DELETE],
             edits.kinds_seen[KIND_MOVE], edits.kinds_seen[KIND_READ],
             edits.peak_length, CAP);
    $display("Outcomes: %0d done, %0d full, %0d no-op, %0d out of range; %0d mismatches.",
             edits.status_seen[ST_DONE], edits.status_seen[ST_FULL],
             edits.status_seen[ST_NOTHING], edits.status_seen[ST_RANGE], edits.errors);
    if (edits.errors == 0) begin
      $display("** gap_buffer_text_store: PASSED **");
    end else begin
      $display("** gap_buffer_text_store: FAILED **");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Run timed out with %0d results outstanding.", edits.awaited.size());
    $display("** gap_buffer_text_store: FAILED **");
    $finish;
  end

endmodule
